@@ design/wavelet_row_transform_haar_d4_macros.svh @@
// Assertion macros for the wavelet row transform block.
// Included by the top level; relies on clk and rst_n being in scope.
`ifndef WAVELET_ROW_TRANSFORM_HAAR_D4_MACROS_SVH
`define WAVELET_ROW_TRANSFORM_HAAR_D4_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define WRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/wrt_pkg.sv @@
// Shared constants, command/status types and filter taps for the wavelet row transform.
// No dependencies; used by wrt_ctrl, wrt_datapath and the top level.
`default_nettype none

package wrt_pkg;

    localparam int MAX_LEN     = 64;
    localparam int SAMPLE_BITS = 20;
    localparam int HALF_MAX    = MAX_LEN / 2;
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int CNT_W       = $clog2(MAX_LEN) + 1;
    localparam int HALF_W      = $clog2(HALF_MAX) + 1;
    localparam int TAP_W       = 2;
    localparam int NUM_TAPS    = 4;
    localparam int COEF_W      = 17;
    localparam int PROD_W      = SAMPLE_BITS + COEF_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int FRAC_BITS   = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 6;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_KIND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF    = 2'd2;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(HALF_MAX);

    // D4 taps in Q1.15, Haar weights chosen so the same MAC/round path applies.
    localparam logic signed [COEF_W-1:0] C0        = 17'sd15826;
    localparam logic signed [COEF_W-1:0] C1        = 17'sd27411;
    localparam logic signed [COEF_W-1:0] C2        = 17'sd7345;
    localparam logic signed [COEF_W-1:0] C3        = -17'sd4240;
    localparam logic signed [COEF_W-1:0] HAAR_HALF = 17'sd16384;
    localparam logic signed [COEF_W-1:0] HAAR_ONE  = 17'sd32768;
    localparam logic signed [COEF_W-1:0] ZERO      = 17'sd0;

    typedef struct packed {
        logic              kind;     // 0 Haar, 1 D4
        logic              inverse;  // 0 analysis, 1 synthesis
        logic [HALF_W-1:0] half;     // effective half length, 1..HALF_MAX
    } wrt_cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic              first;
        logic [ADDR_W-1:0] k;
        logic [TAP_W-1:0]  tap;
        logic              out_load;
        logic              out_last;
    } wrt_cmd_t;

    typedef struct packed {
        logic out_free;
    } wrt_status_t;

    // Weight for operand 'tap'. sel: detail (forward) or odd sample (inverse).
    function automatic logic signed [COEF_W-1:0] tap_coef(
        input logic             kind,
        input logic             inverse,
        input logic             sel,
        input logic [TAP_W-1:0] tap
    );
        logic signed [COEF_W-1:0] t0;
        logic signed [COEF_W-1:0] t1;
        logic signed [COEF_W-1:0] t2;
        logic signed [COEF_W-1:0] t3;
        logic signed [COEF_W-1:0] res;
        if (!inverse && !kind) begin
            t0 = HAAR_HALF;
            t1 = sel ? -HAAR_HALF : HAAR_HALF;
            t2 = ZERO;
            t3 = ZERO;
        end
        else if (inverse && !kind) begin
            t0 = ZERO;
            t1 = ZERO;
            t2 = HAAR_ONE;
            t3 = sel ? -HAAR_ONE : HAAR_ONE;
        end
        else if (!inverse) begin
            t0 = sel ? C3 : C0;
            t1 = sel ? -C2 : C1;
            t2 = sel ? C1 : C2;
            t3 = sel ? -C0 : C3;
        end
        else begin
            t0 = sel ? C3 : C2;
            t1 = sel ? -C0 : C1;
            t2 = sel ? C1 : C0;
            t3 = sel ? -C2 : C3;
        end
        case (tap)
            2'd0:    res = t0;
            2'd1:    res = t1;
            2'd2:    res = t2;
            default: res = t3;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/wrt_ctrl.sv @@
// Controller FSM for the wavelet row transform: sample loading and per-output sequencing.
// Depends on wrt_pkg; drives wrt_datapath through wrt_cmd_t.
`default_nettype none

module wrt_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire wrt_pkg::wrt_cfg_t    cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire wrt_pkg::wrt_status_t status,
    output wrt_pkg::wrt_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_PUT   = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [wrt_pkg::CNT_W-1:0]      load_cnt_reg, load_cnt_next;
    logic [wrt_pkg::ADDR_W-1:0]     k_reg, k_next;
    logic [wrt_pkg::TAP_W-1:0]      tap_reg, tap_next;
    logic                           drain_reg, drain_next;
    logic [wrt_pkg::CNT_W-1:0]      row_len;
    logic [wrt_pkg::CNT_W-1:0]      cnt_inc;
    logic                           k_is_last;

    assign row_len   = wrt_pkg::CNT_W'({cfg.half, 1'b0});
    assign cnt_inc   = load_cnt_reg + wrt_pkg::CNT_W'(1);
    assign k_is_last = (wrt_pkg::CNT_W'(k_reg) == row_len - wrt_pkg::CNT_W'(1));
    assign in_ready  = (state_reg == S_LOAD);

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        k_next        = k_reg;
        tap_next      = tap_reg;
        drain_next    = drain_reg;
        cmd           = '0;
        cmd.wr_addr   = load_cnt_reg[wrt_pkg::ADDR_W-1:0];
        cmd.k         = k_reg;
        cmd.tap       = tap_reg;
        cmd.first     = (tap_reg == '0);
        cmd.out_last  = k_is_last;
        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.wr_en = 1'b1;
                    if (cnt_inc >= row_len)
                    begin
                        load_cnt_next = '0;
                        k_next        = '0;
                        tap_next      = '0;
                        state_next    = S_ISSUE;
                    end
                    else
                    begin
                        load_cnt_next = cnt_inc;
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.rd_en = 1'b1;
                tap_next  = tap_reg + wrt_pkg::TAP_W'(1);
                if (tap_reg == wrt_pkg::TAP_W'(wrt_pkg::NUM_TAPS - 1))
                begin
                    drain_next = 1'b0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait for read data -> product -> accumulator
                drain_next = 1'b1;
                if (drain_reg)
                    state_next = S_PUT;
            end
            S_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    tap_next     = '0;
                    if (k_is_last)
                        state_next = S_LOAD;
                    else
                    begin
                        k_next     = k_reg + wrt_pkg::ADDR_W'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= '0;
            k_reg        <= '0;
            tap_reg      <= '0;
            drain_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            k_reg        <= k_next;
            tap_reg      <= tap_next;
            drain_reg    <= drain_next;
        end
    end

endmodule

`default_nettype wire

@@ design/wrt_datapath.sv @@
// Datapath: row memory, operand address generation, serial MAC, rounding and output register.
// Depends on wrt_pkg; sequenced by wrt_ctrl.
`default_nettype none

module wrt_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire wrt_pkg::wrt_cfg_t                   cfg,
    input  wire wrt_pkg::wrt_cmd_t                   cmd,
    output wrt_pkg::wrt_status_t                     status,
    input  wire logic signed [wrt_pkg::SAMPLE_BITS-1:0] sample,
    output logic signed [wrt_pkg::SAMPLE_BITS-1:0]   coeff,
    output logic                                     last,
    output logic                                     out_valid,
    input  wire logic                                out_ready
);

    localparam int CW = wrt_pkg::CNT_W;
    localparam int AW = wrt_pkg::ADDR_W;
    localparam int SB = wrt_pkg::SAMPLE_BITS;
    localparam int AC = wrt_pkg::ACC_W;
    localparam logic signed [AC-1:0] SAT_HI   = AC'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [AC-1:0] SAT_LO   = -SAT_HI - AC'(1);
    localparam logic signed [AC-1:0] ROUND_HF = AC'(64'sd1 <<< (wrt_pkg::FRAC_BITS - 1));

    logic signed [SB-1:0]             mem [wrt_pkg::MAX_LEN];

    logic [CW-1:0]                    row_len;
    logic [CW-1:0]                    half_w;
    logic                             is_detail;
    logic [AW-1:0]                    fwd_i;
    logic [CW-1:0]                    fwd_sum;
    logic [CW-1:0]                    fwd_idx;
    logic [AW-1:0]                    inv_i;
    logic [AW-1:0]                    inv_p;
    logic [AW-1:0]                    inv_idx;
    logic [AW-1:0]                    rd_addr;
    logic                             sel;

    logic signed [SB-1:0]             rd_data_reg;
    logic signed [wrt_pkg::COEF_W-1:0] coef_reg;
    logic signed [wrt_pkg::PROD_W-1:0] prod_reg;
    logic signed [AC-1:0]             acc_reg;
    logic                             v1_reg, f1_reg, v2_reg, f2_reg;

    logic signed [AC-1:0]             rounded;
    logic signed [AC-1:0]             shifted;
    logic signed [SB-1:0]             result;

    logic                             out_valid_reg;
    logic signed [SB-1:0]             coeff_reg;
    logic                             last_reg;

    // Operand addressing
    assign half_w    = CW'(cfg.half);
    assign row_len   = CW'({cfg.half, 1'b0});
    assign is_detail = (CW'(cmd.k) >= half_w);
    assign fwd_i     = is_detail ? cmd.k - AW'(cfg.half) : cmd.k;
    assign fwd_sum   = CW'({fwd_i, 1'b0}) + CW'(cmd.tap);
    assign fwd_idx   = (fwd_sum >= row_len) ? fwd_sum - row_len : fwd_sum;  // periodic wrap
    assign inv_i     = cmd.k >> 1;
    assign inv_p     = (inv_i == '0) ? AW'(cfg.half) - AW'(1) : inv_i - AW'(1);

    always_comb
    begin
        case (cmd.tap)
            2'd0:    inv_idx = inv_p;
            2'd1:    inv_idx = inv_p + AW'(cfg.half);
            2'd2:    inv_idx = inv_i;
            default: inv_idx = inv_i + AW'(cfg.half);
        endcase
    end

    assign rd_addr = cfg.inverse ? inv_idx : fwd_idx[AW-1:0];
    assign sel     = cfg.inverse ? cmd.k[0] : is_detail;

    // Row memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr] <= sample;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // MAC pipeline: operand/coef -> product -> accumulate
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            coef_reg <= wrt_pkg::tap_coef(cfg.kind, cfg.inverse, sel, cmd.tap);
        if (v1_reg)
            prod_reg <= rd_data_reg * coef_reg;
        if (v2_reg)
            acc_reg <= f2_reg ? AC'(prod_reg) : acc_reg + AC'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            f1_reg <= 1'b0;
            v2_reg <= 1'b0;
            f2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            f1_reg <= cmd.first;
            v2_reg <= v1_reg;
            f2_reg <= f1_reg;
        end
    end

    // Round half up, floor shift, saturate
    assign rounded = acc_reg + ROUND_HF;
    assign shifted = rounded >>> wrt_pkg::FRAC_BITS;
    assign result  = (shifted > SAT_HI) ? SAT_HI[SB-1:0] :
                     (shifted < SAT_LO) ? SAT_LO[SB-1:0] : shifted[SB-1:0];

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            coeff_reg <= result;
            last_reg  <= cmd.out_last;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign coeff           = coeff_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

@@ design/wavelet_row_transform_haar_d4.sv @@
// Top level of the one-level 1-D wavelet row transform (Haar / Daubechies D4).
// Depends on wrt_pkg, wrt_ctrl, wrt_datapath and the assertion macro header.
//
// Usage:
//   - Config port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready.
//     Index 0 wavelet_kind, 1 inverse_mode, 2 half_len; other indexes ignored.
//     Write only while the block is idle (no row being emitted).
//   - Input channel (in_valid/in_ready, sample): one Q12.8 word per cycle while
//     a row is being collected. half_len 0 acts as 1, above 32 acts as 32.
//   - When the 2*half_len-th word of a row is taken, in_ready drops and the
//     transformed row goes out on (out_valid/out_ready, coeff, last); last
//     marks the final word. Forward: approximations then details.
//   - Each output word takes 4 memory reads through the single read port
//     feeding the shared multiply-accumulate, then passes the product and
//     accumulator registers before it is loaded into the output register.
//   - A stalled receiver holds the output register; the next word waits in
//     the accumulator. Loading of the next row resumes once the final word is
//     in the output register, even if it has not yet been taken.
//   - Reset clears the registers to Haar, forward, half_len 32 and empties the
//     row; stored samples are not cleared (every read hits a word of this row).
`default_nettype none
`include "wavelet_row_transform_haar_d4_macros.svh"

module wavelet_row_transform_haar_d4 (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [wrt_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [wrt_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic signed [wrt_pkg::SAMPLE_BITS-1:0]  sample,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic signed [wrt_pkg::SAMPLE_BITS-1:0]       coeff,
    output logic                                         last
);

    logic                         kind_reg, kind_next;
    logic                         inverse_reg, inverse_next;
    logic [wrt_pkg::HALF_W-1:0]   half_len_reg, half_len_next;
    logic                         cfg_write;
    wrt_pkg::wrt_cfg_t            cfg;
    wrt_pkg::wrt_cmd_t            cmd;
    wrt_pkg::wrt_status_t         status;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Configuration registers
    always_comb
    begin
        kind_next     = kind_reg;
        inverse_next  = inverse_reg;
        half_len_next = half_len_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                wrt_pkg::REG_KIND:    kind_next     = cfg_data[0];
                wrt_pkg::REG_INVERSE: inverse_next  = cfg_data[0];
                wrt_pkg::REG_HALF:    half_len_next = cfg_data[wrt_pkg::HALF_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= 1'b0;
            inverse_reg  <= 1'b0;
            half_len_reg <= wrt_pkg::HALF_RESET;
        end
        else
        begin
            kind_reg     <= kind_next;
            inverse_reg  <= inverse_next;
            half_len_reg <= half_len_next;
        end
    end

    // Effective half length: clamp into 1..HALF_MAX
    assign cfg.kind    = kind_reg;
    assign cfg.inverse = inverse_reg;
    assign cfg.half    = (half_len_reg == '0) ? wrt_pkg::HALF_W'(1) :
                         (half_len_reg > wrt_pkg::HALF_RESET) ? wrt_pkg::HALF_RESET :
                         half_len_reg;

    wrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wrt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .sample    (sample),
        .coeff     (coeff),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    // Controller never overwrites an output word that is still waiting.
    `WRT_ASSERT_SAME(a_no_overwrite, cmd.out_load, status.out_free, "output word overwritten")
    // Memory writes happen only on an accepted input word.
    `WRT_ASSERT_SAME(a_write_on_accept, cmd.wr_en, in_valid && in_ready, "stray memory write")
    // After the final word of a row is loaded, loading of the next row opens.
    `WRT_ASSERT_NEXT(a_reopen_after_row, cmd.out_load && cmd.out_last, in_ready, "input not reopened")
    // No read issued while the block is collecting samples.
    `WRT_ASSERT_SAME(a_no_read_in_load, cmd.rd_en, !in_ready && !cmd.out_load, "read during load")

endmodule

`default_nettype wire
